// ===== hdl/lee_pkg.sv =====
package lee_pkg;

    localparam int STEP_W = 32;
    localparam int NV_W   = STEP_W + 2;

    localparam logic [STEP_W-1:0] STEP_MAX = 32'h7FFF_FFFF;
    localparam logic [STEP_W-1:0] STEP_MIN = 32'h8000_0000;
    localparam logic [7:0]        LVL_MAX  = 8'hFF;

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    localparam logic [2:0] MODE_RAISE   = 3'd0;
    localparam logic [2:0] MODE_LOWER   = 3'd1;
    localparam logic [2:0] MODE_SET     = 3'd2;
    localparam logic [2:0] MODE_FADE    = 3'd3;
    localparam logic [2:0] MODE_GLOW    = 3'd4;
    localparam logic [2:0] MODE_FLICKER = 3'd5;
    localparam logic [2:0] MODE_STROBE  = 3'd6;

    localparam logic [2:0] CFG_EFFECT_MODE = 3'd0;
    localparam logic [2:0] CFG_LEVEL_A     = 3'd1;
    localparam logic [2:0] CFG_LEVEL_B     = 3'd2;
    localparam logic [2:0] CFG_TIME_A      = 3'd3;
    localparam logic [2:0] CFG_TIME_B      = 3'd4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] random_byte;
        logic [7:0] level_in;
    } lee_in_t;

    typedef struct packed {
        logic [7:0] light_level;
        logic       running;
    } lee_out_t;

endpackage

// ===== hdl/lee_div.sv =====
module lee_div
    import lee_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [8+FRAC_BITS-1:0] dividend,
    input  logic [7:0]             divisor,
    output logic                   done,
    output logic [8+FRAC_BITS-1:0] quotient
);

    localparam int NUM_W = 8 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [7:0]       rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [7:0]       dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CNT_W'(NUM_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // one quotient bit per cycle, restoring
            rem_next = fits ? diff[7:0] : trial[7:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/light_effect_engine.sv =====
// channel  dir  handshake           payload
// in       in   in_valid/in_ready   lee_in_t  (req_type, random_byte, level_in)
// out      out  out_valid/out_ready lee_out_t (light_level, running)
// cfg      in   cfg_we              cfg_addr, cfg_wdata
//
// Ticks, loads and all other starts go from accept straight to the final state.
// Fade and glow starts with a nonzero divisor (level B for fade, time A for glow) first
// wait in the divide state for the serial divider, producing one quotient bit a cycle.
// One item at a time; in_ready returns once the result enters the output register.
// A stalled output holds the block in its final state until the register frees.
// Reset clears all configuration and effect state to zero.
module light_effect_engine
    import lee_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lee_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lee_out_t out_data,
    input  logic     cfg_we,
    input  logic [2:0] cfg_addr,
    input  logic [7:0] cfg_wdata
);

    localparam int NUM_W = 8 + FRAC_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]        state_reg, state_next;

    logic [2:0]        effect_mode_reg;
    logic [7:0]        level_a_reg, level_b_reg, time_a_reg, time_b_reg;

    logic [7:0]        level_reg, level_next;
    logic [7:0]        dwell_reg, dwell_next;
    logic [2:0]        active_mode_reg, active_mode_next;
    logic              active_reg, active_next;
    logic [7:0]        upper_level_reg, upper_level_next;
    logic [7:0]        lower_level_reg, lower_level_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              rising_reg, rising_next;
    logic [7:0]        upper_dwell_reg, upper_dwell_next;
    logic [7:0]        lower_dwell_reg, lower_dwell_next;
    logic              neg_reg, neg_next;

    logic              out_valid_reg, out_valid_next;
    lee_out_t          out_data_reg, out_data_next;

    logic              accept;
    logic [8:0]        raise_sum;
    logic              up_dir;
    logic [7:0]        d_mag;
    logic [7:0]        divisor;
    logic              div_start;
    logic              div_done;
    logic [NUM_W-1:0]  div_quo;
    logic [STEP_W-1:0] quo_ext;
    logic signed [NV_W-1:0] step_ext;
    logic signed [NV_W-1:0] whole;
    logic signed [NV_W-1:0] nv;
    logic signed [NV_W-1:0] upper_ext;
    logic signed [NV_W-1:0] lower_ext;
    logic              at_upper_rise, at_upper_fall, at_lower_fall;
    logic [STEP_W-1:0] step_neg;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    assign raise_sum = {1'b0, level_reg} + {1'b0, level_a_reg};
    assign up_dir    = level_reg <= level_a_reg;
    assign d_mag     = up_dir ? level_a_reg - level_reg : level_reg - level_a_reg;
    assign divisor   = (effect_mode_reg == MODE_FADE) ? level_b_reg : time_a_reg;
    assign quo_ext   = STEP_W'(div_quo);

    assign step_ext  = NV_W'(signed'(step_reg));
    assign whole     = step_ext >>> FRAC_BITS;
    assign nv        = whole + signed'(NV_W'(level_reg));
    assign upper_ext = signed'(NV_W'(upper_level_reg));
    assign lower_ext = signed'(NV_W'(lower_level_reg));
    assign at_upper_rise = nv >= upper_ext;
    assign at_upper_fall = nv <= upper_ext;
    assign at_lower_fall = nv <= lower_ext;
    assign step_neg  = (step_reg == STEP_MIN) ? STEP_MAX : STEP_W'(0) - step_reg;

    always_comb
    begin
        state_next       = state_reg;
        level_next       = level_reg;
        dwell_next       = dwell_reg;
        active_mode_next = active_mode_reg;
        active_next      = active_reg;
        upper_level_next = upper_level_reg;
        lower_level_next = lower_level_reg;
        step_next        = step_reg;
        rising_next      = rising_reg;
        upper_dwell_next = upper_dwell_reg;
        lower_dwell_next = lower_dwell_reg;
        neg_next         = neg_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_data_next    = out_data_reg;
        div_start        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_FIN;
                    unique case (in_data.req_type)
                        REQ_TICK:
                        begin
                            if (active_reg && dwell_reg != 8'd0)
                            begin
                                dwell_next = dwell_reg - 8'd1;
                            end
                            else if (active_reg)
                            begin
                                unique case (active_mode_reg)
                                    MODE_FADE:
                                    begin
                                        if (rising_reg ? at_upper_rise : at_upper_fall)
                                        begin
                                            level_next  = upper_level_reg;
                                            active_next = 1'b0;
                                        end
                                        else
                                        begin
                                            level_next = nv[7:0];
                                        end
                                    end
                                    MODE_GLOW:
                                    begin
                                        if (rising_reg && at_upper_rise)
                                        begin
                                            level_next  = upper_level_reg;
                                            step_next   = step_neg;
                                            rising_next = 1'b0;
                                        end
                                        else if (!rising_reg && at_lower_fall)
                                        begin
                                            level_next  = lower_level_reg;
                                            step_next   = step_neg;
                                            rising_next = 1'b1;
                                        end
                                        else
                                        begin
                                            level_next = nv[7:0];
                                        end
                                    end
                                    MODE_FLICKER:
                                    begin
                                        if (level_reg == upper_level_reg)
                                        begin
                                            level_next = lower_level_reg;
                                            dwell_next = {5'd0, in_data.random_byte[2:0]} + 8'd1;
                                        end
                                        else
                                        begin
                                            level_next = upper_level_reg;
                                            dwell_next = {3'd0, in_data.random_byte[4:0]} + 8'd1;
                                        end
                                    end
                                    MODE_STROBE:
                                    begin
                                        if (level_reg == upper_level_reg)
                                        begin
                                            level_next = lower_level_reg;
                                            dwell_next = lower_dwell_reg;
                                        end
                                        else
                                        begin
                                            level_next = upper_level_reg;
                                            dwell_next = upper_dwell_reg;
                                        end
                                    end
                                    default:
                                    begin
                                        active_next = 1'b0;
                                    end
                                endcase
                            end
                        end
                        REQ_START:
                        begin
                            unique case (effect_mode_reg) inside
                                MODE_RAISE:
                                begin
                                    level_next = raise_sum[8] ? LVL_MAX : raise_sum[7:0];
                                end
                                MODE_LOWER:
                                begin
                                    level_next = (level_a_reg > level_reg) ? 8'd0
                                                 : level_reg - level_a_reg;
                                end
                                MODE_SET:
                                begin
                                    level_next = level_a_reg;
                                end
                                MODE_FADE, MODE_GLOW:
                                begin
                                    upper_level_next = level_a_reg;
                                    if (effect_mode_reg == MODE_GLOW)
                                    begin
                                        lower_level_next = level_b_reg;
                                    end
                                    rising_next      = up_dir;
                                    dwell_next       = 8'd0;
                                    active_mode_next = effect_mode_reg;
                                    active_next      = 1'b1;
                                    neg_next         = !up_dir;
                                    if (divisor == 8'd0)
                                    begin
                                        step_next = up_dir ? STEP_MAX : STEP_MIN;
                                    end
                                    else
                                    begin
                                        div_start  = 1'b1;
                                        state_next = ST_DIV;
                                    end
                                end
                                MODE_FLICKER:
                                begin
                                    upper_level_next = level_a_reg;
                                    lower_level_next = level_b_reg;
                                    level_next       = level_a_reg;
                                    dwell_next       = {1'b0, in_data.random_byte[6], 6'd0} + 8'd1;
                                    active_mode_next = MODE_FLICKER;
                                    active_next      = 1'b1;
                                end
                                MODE_STROBE:
                                begin
                                    upper_level_next = level_a_reg;
                                    lower_level_next = level_b_reg;
                                    upper_dwell_next = time_a_reg;
                                    lower_dwell_next = time_b_reg;
                                    dwell_next       = time_a_reg;
                                    level_next       = level_a_reg;
                                    active_mode_next = MODE_STROBE;
                                    active_next      = 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                        REQ_LOAD:
                        begin
                            level_next = in_data.level_in;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    step_next  = neg_reg ? STEP_W'(0) - quo_ext : quo_ext;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.light_level = level_reg;
                    out_data_next.running     = active_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    lee_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({d_mag, FRAC_BITS'(0)}),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            effect_mode_reg <= '0;
            level_a_reg     <= '0;
            level_b_reg     <= '0;
            time_a_reg      <= '0;
            time_b_reg      <= '0;
            level_reg       <= '0;
            dwell_reg       <= '0;
            active_mode_reg <= '0;
            active_reg      <= 1'b0;
            upper_level_reg <= '0;
            lower_level_reg <= '0;
            step_reg        <= '0;
            rising_reg      <= 1'b0;
            upper_dwell_reg <= '0;
            lower_dwell_reg <= '0;
            neg_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            level_reg       <= level_next;
            dwell_reg       <= dwell_next;
            active_mode_reg <= active_mode_next;
            active_reg      <= active_next;
            upper_level_reg <= upper_level_next;
            lower_level_reg <= lower_level_next;
            step_reg        <= step_next;
            rising_reg      <= rising_next;
            upper_dwell_reg <= upper_dwell_next;
            lower_dwell_reg <= lower_dwell_next;
            neg_reg         <= neg_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_EFFECT_MODE: effect_mode_reg <= cfg_wdata[2:0];
                    CFG_LEVEL_A:     level_a_reg     <= cfg_wdata;
                    CFG_LEVEL_B:     level_b_reg     <= cfg_wdata;
                    CFG_TIME_A:      time_a_reg      <= cfg_wdata;
                    CFG_TIME_B:      time_b_reg      <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
